>>> rtl/core/ifd_pkg.sv
package ifd_pkg;

	localparam int TICK_W  = 15;
	localparam int CODE_W  = 32;
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 7;

	localparam int MAX_FRAME_SYMBOLS_DEF = 96;
	localparam int NEC_DATA_BITS         = 32;

	localparam logic [CODE_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [CODE_W-1:0] FNV_PRIME = 32'd16777619;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_NEC    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HASH   = 2'd2;

	// Timing targets and tolerances, microseconds.
	localparam int LEAD_MARK_T  = 9000;
	localparam int LEAD_MARK_W  = 2200;
	localparam int RPT_SPACE_T  = 2250;
	localparam int RPT_SPACE_W  = 700;
	localparam int DATA_SPACE_T = 4500;
	localparam int DATA_SPACE_W = 1200;
	localparam int BIT_T        = 560;
	localparam int BIT_W        = 320;
	localparam int ONE_SPACE_T  = 1690;
	localparam int ONE_SPACE_W  = 500;

	// Reciprocal of five, exact for every 16-bit dividend.
	localparam logic [16:0] RECIP5 = 17'd52429;
	localparam int RECIP5_SH = 18;

	// Comparison outcome folded into the hash.
	localparam logic [1:0] CMP_SHORTER = 2'd0;
	localparam logic [1:0] CMP_SIMILAR = 2'd1;
	localparam logic [1:0] CMP_LONGER  = 2'd2;

	typedef struct packed {
		logic cmp;   // compare the operand pair and latch the outcome
		logic fold;  // fold the latched outcome into the hash
		logic clear; // return the hash to its basis
	} ifd_hash_ctrl_t;

	// True when v lies inside [t - w, t + w].
	function automatic logic near(input logic [TICK_W-1:0] v, input int t, input int w);
		logic [TICK_W:0] lo;
		logic [TICK_W:0] hi;
		lo = (TICK_W+1)'(t - w);
		hi = (TICK_W+1)'(t + w);
		return ({1'b0, v} >= lo) && ({1'b0, v} <= hi);
	endfunction

	// Integer division by five through a reciprocal multiply.
	function automatic logic [TICK_W-3:0] div5(input logic [TICK_W-1:0] v);
		logic [TICK_W+16:0] p;
		p = {17'b0, v} * {{TICK_W{1'b0}}, RECIP5};
		return p[RECIP5_SH +: TICK_W-2];
	endfunction

endpackage

>>> rtl/core/ifd_sym_if.sv
interface ifd_sym_if;
	import ifd_pkg::*;

	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] mark_ticks;
	logic [TICK_W-1:0] space_ticks;
	logic              frame_end;

	modport source (output valid, output mark_ticks, output space_ticks, output frame_end,
		input ready);
	modport sink (input valid, input mark_ticks, input space_ticks, input frame_end,
		output ready);
endinterface

>>> rtl/core/ifd_res_if.sv
interface ifd_res_if;
	import ifd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code;
	logic [KIND_W-1:0] kind;

	modport source (output valid, output code, output kind, input ready);
	modport sink (input valid, input code, input kind, output ready);
endinterface

>>> rtl/core/ir_frame_decoder.sv
// Infrared frame decoder. Each input beat carries one mark/space pair in
// microsecond ticks, with frame_end set on the last pair of a frame. The first
// pair must be an NEC leader; a short leader space marks a repeat frame, and
// otherwise the next 32 pairs carry the code, most significant bit first, told
// apart by the length of the space. Every duration is also compared with the
// same level of the next pair and folded into a 32-bit FNV-1 hash. At frame end
// one result beat may follow: an NEC code (kind 0), a repeat (kind 1, code 0),
// or the hash (kind 2, a zero hash sent as 1) when the frame is not valid NEC
// and holds at least six pairs; frames shorter than two pairs give nothing.
// Pairs beyond MAX_FRAME_SYMBOLS are dropped, but their frame_end still ends
// the frame. The leader pair and dropped pairs are handled in the idle state;
// every other pair then passes compare-mark, fold-mark, compare-space and
// fold-space, as a single compare-and-multiply hash unit works through the mark
// and then the space, each a compare step and then a multiply step. A finish
// state settles the result; the last pair waits there while an earlier result is still not taken.
module ir_frame_decoder #(
	parameter int MAX_FRAME_SYMBOLS = ifd_pkg::MAX_FRAME_SYMBOLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ifd_sym_if.sink   sym,
	ifd_res_if.source res
);
	import ifd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP_MARK,
		S_FOLD_MARK,
		S_CMP_SPACE,
		S_FOLD_SPACE,
		S_FINISH
	} state_t;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_FRAME_SYMBOLS);
	localparam logic [COUNT_W-1:0] DATA_LAST   = COUNT_W'(NEC_DATA_BITS);
	localparam logic [COUNT_W-1:0] NEC_MIN     = COUNT_W'(NEC_DATA_BITS + 1);

	state_t              state_q;
	logic [COUNT_W-1:0]  count_q;
	logic                nec_ok_q;
	logic                repeat_q;
	logic [CODE_W-1:0]   shift_q;
	logic [TICK_W-1:0]   prev_mark_q;
	logic [TICK_W-1:0]   prev_space_q;
	logic [TICK_W-1:0]   old_mark_q;
	logic [TICK_W-1:0]   old_space_q;
	logic                last_q;
	logic                out_valid_q;
	logic [CODE_W-1:0]   out_code_q;
	logic [KIND_W-1:0]   out_kind_q;

	ifd_hash_ctrl_t      hash_ctrl;
	logic [TICK_W-1:0]   dur_a;
	logic [TICK_W-1:0]   dur_b;
	logic [CODE_W-1:0]   hash;

	logic                accept;
	logic                lead_mark;
	logic                lead_rpt;
	logic                lead_data;
	logic                bit_mark;
	logic                bit_zero;
	logic                bit_one;
	logic                finish_go;
	logic                hit;
	logic [CODE_W-1:0]   hit_code;
	logic [KIND_W-1:0]   hit_kind;

	assign sym.ready = (state_q == S_IDLE);
	assign accept    = sym.valid && sym.ready;

	// Timing windows of the current pair.
	assign lead_mark = near(sym.mark_ticks, LEAD_MARK_T, LEAD_MARK_W);
	assign lead_rpt  = near(sym.space_ticks, RPT_SPACE_T, RPT_SPACE_W);
	assign lead_data = near(sym.space_ticks, DATA_SPACE_T, DATA_SPACE_W);
	assign bit_mark  = near(sym.mark_ticks, BIT_T, BIT_W);
	assign bit_zero  = near(sym.space_ticks, BIT_T, BIT_W);
	assign bit_one   = near(sym.space_ticks, ONE_SPACE_T, ONE_SPACE_W);

	// The hash unit sees the marks first, then the spaces, of the two latest pairs.
	always_comb begin
		if (state_q == S_CMP_SPACE) begin
			dur_a = old_space_q;
			dur_b = prev_space_q;
		end else begin
			dur_a = old_mark_q;
			dur_b = prev_mark_q;
		end
	end

	// The frame may be retired once the output register is free or being emptied.
	assign finish_go = (state_q == S_FINISH) && (!out_valid_q || res.ready);

	assign hash_ctrl.cmp   = (state_q == S_CMP_MARK) || (state_q == S_CMP_SPACE);
	assign hash_ctrl.fold  = (state_q == S_FOLD_MARK) || (state_q == S_FOLD_SPACE);
	assign hash_ctrl.clear = finish_go;

	ifd_hash_unit u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (hash_ctrl),
		.dur_a  (dur_a),
		.dur_b  (dur_b),
		.hash   (hash)
	);

	// Frame verdict, in order of precedence.
	always_comb begin
		hit      = 1'b0;
		hit_code = '0;
		hit_kind = KIND_NEC;
		priority if (repeat_q && count_q >= COUNT_W'(2) && count_q <= COUNT_W'(4)) begin
			hit      = 1'b1;
			hit_kind = KIND_REPEAT;
		end else if (nec_ok_q && count_q >= NEC_MIN) begin
			hit      = 1'b1;
			hit_code = shift_q;
			hit_kind = KIND_NEC;
		end else if (count_q >= COUNT_W'(6)) begin
			hit      = 1'b1;
			hit_code = (hash == '0) ? CODE_W'(1) : hash;
			hit_kind = KIND_HASH;
		end else begin
			hit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			nec_ok_q     <= 1'b1;
			repeat_q     <= 1'b0;
			shift_q      <= '0;
			prev_mark_q  <= '0;
			prev_space_q <= '0;
			old_mark_q   <= '0;
			old_space_q  <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_code_q   <= '0;
			out_kind_q   <= KIND_NEC;
		end else begin
			// A retiring frame reloads the output register in the same cycle.
			if (res.valid && res.ready && !finish_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= sym.frame_end;
						if (count_q < COUNT_LIMIT) begin
							count_q      <= count_q + COUNT_W'(1);
							old_mark_q   <= prev_mark_q;
							old_space_q  <= prev_space_q;
							prev_mark_q  <= sym.mark_ticks;
							prev_space_q <= sym.space_ticks;
							if (count_q == '0) begin
								repeat_q <= lead_mark && lead_rpt;
								nec_ok_q <= lead_mark && lead_data;
								state_q  <= sym.frame_end ? S_FINISH : S_IDLE;
							end else begin
								if (count_q <= DATA_LAST) begin
									nec_ok_q <= nec_ok_q && bit_mark && (bit_zero || bit_one);
									shift_q  <= {shift_q[CODE_W-2:0], !bit_zero && bit_one};
								end
								state_q <= S_CMP_MARK;
							end
						end else begin
							state_q <= sym.frame_end ? S_FINISH : S_IDLE;
						end
					end
				end
				S_CMP_MARK:  state_q <= S_FOLD_MARK;
				S_FOLD_MARK: state_q <= S_CMP_SPACE;
				S_CMP_SPACE: state_q <= S_FOLD_SPACE;
				S_FOLD_SPACE: begin
					state_q <= last_q ? S_FINISH : S_IDLE;
				end
				S_FINISH: begin
					if (finish_go) begin
						out_valid_q  <= hit;
						out_code_q   <= hit_code;
						out_kind_q   <= hit_kind;
						count_q      <= '0;
						nec_ok_q     <= 1'b1;
						repeat_q     <= 1'b0;
						shift_q      <= '0;
						prev_mark_q  <= '0;
						prev_space_q <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.code  = out_code_q;
	assign res.kind  = out_kind_q;

	// The pair count never passes the frame limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_LIMIT)
		else $error("pair count exceeds the frame limit");

	// A hash result is never zero.
	a_hash_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_HASH) |-> (res.code != '0))
		else $error("hash result of zero");

	// A repeat carries a zero code.
	a_repeat_code: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind == KIND_REPEAT) |-> (res.code == '0))
		else $error("repeat result with a nonzero code");

	// Once a frame is retired the next cycle starts a fresh frame.
	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		finish_go |=> (count_q == '0 && state_q == S_IDLE))
		else $error("frame state not cleared after frame end");
endmodule

>>> rtl/core/ifd_hash_unit.sv
module ifd_hash_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ifd_pkg::ifd_hash_ctrl_t       ctrl,
	input  logic [ifd_pkg::TICK_W-1:0]    dur_a,
	input  logic [ifd_pkg::TICK_W-1:0]    dur_b,
	output logic [ifd_pkg::CODE_W-1:0]    hash
);
	import ifd_pkg::*;

	logic [TICK_W:0]   a_scaled;
	logic [TICK_W:0]   b_scaled;
	logic [1:0]        cmp_d;
	logic [1:0]        cmp_q;
	logic [CODE_W-1:0] hash_q;
	logic [CODE_W-1:0] prod;

	// A duration counts as longer when it exceeds the other by more than a fifth.
	assign a_scaled = {1'b0, dur_a} + {3'b0, div5(dur_a)};
	assign b_scaled = {1'b0, dur_b} + {3'b0, div5(dur_b)};

	always_comb begin
		priority if (a_scaled < {1'b0, dur_b}) begin
			cmp_d = CMP_LONGER;
		end else if (b_scaled < {1'b0, dur_a}) begin
			cmp_d = CMP_SHORTER;
		end else begin
			cmp_d = CMP_SIMILAR;
		end
	end

	assign prod = hash_q * FNV_PRIME;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q  <= CMP_SIMILAR;
			hash_q <= FNV_BASIS;
		end else begin
			if (ctrl.cmp) begin
				cmp_q <= cmp_d;
			end
			if (ctrl.clear) begin
				hash_q <= FNV_BASIS;
			end else if (ctrl.fold) begin
				hash_q <= prod ^ {30'b0, cmp_q};
			end
		end
	end

	assign hash = hash_q;
endmodule

>>> tb/sv/ifd_frame_checker.sv
// Watches both channels of the decoder, keeps its own copy of the frame state,
// and compares every result beat with the oldest predicted one.
module ifd_frame_checker #(
	parameter int MAX_SYMS = ifd_pkg::MAX_FRAME_SYMBOLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ifd_sym_if   sym,
	ifd_res_if   res,
	output int   fail_count,
	output int   pending
);
	import ifd_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [KIND_W-1:0] kind;
	} ir_result_t;

	ir_result_t expected_results[$];

	logic [COUNT_W-1:0] pair_count;
	logic               nec_ok;
	logic               rpt_lead;
	logic [CODE_W-1:0]  nec_code;
	logic [TICK_W-1:0]  last_mark;
	logic [TICK_W-1:0]  last_space;
	logic [CODE_W-1:0]  timing_hash;

	function automatic logic in_window(input int v, input int t, input int w);
		return (v >= t - w) && (v <= t + w);
	endfunction

	task automatic clear_frame();
		pair_count  = '0;
		nec_ok      = 1'b1;
		rpt_lead    = 1'b0;
		nec_code    = '0;
		last_mark   = '0;
		last_space  = '0;
		timing_hash = FNV_BASIS;
	endtask

	// Folds one earlier/later duration comparison into the FNV-1 hash.
	task automatic hash_step(input int a, input int b);
		logic [1:0] outcome;
		if (a + a / 5 < b) begin
			outcome = CMP_LONGER;
		end else if (b + b / 5 < a) begin
			outcome = CMP_SHORTER;
		end else begin
			outcome = CMP_SIMILAR;
		end
		timing_hash = (timing_hash * FNV_PRIME) ^ {30'b0, outcome};
	endtask

	task automatic decode_pair(input logic [TICK_W-1:0] m, input logic [TICK_W-1:0] s,
		input logic last);
		logic bit_val;
		int   n;
		if (pair_count < MAX_SYMS) begin
			if (pair_count == 0) begin
				rpt_lead = in_window(m, LEAD_MARK_T, LEAD_MARK_W) &&
					in_window(s, RPT_SPACE_T, RPT_SPACE_W);
				nec_ok = in_window(m, LEAD_MARK_T, LEAD_MARK_W) &&
					in_window(s, DATA_SPACE_T, DATA_SPACE_W);
			end else begin
				if (pair_count <= NEC_DATA_BITS) begin
					bit_val = 1'b0;
					if (!in_window(m, BIT_T, BIT_W)) nec_ok = 1'b0;
					if (in_window(s, BIT_T, BIT_W)) begin
						bit_val = 1'b0;
					end else if (in_window(s, ONE_SPACE_T, ONE_SPACE_W)) begin
						bit_val = 1'b1;
					end else begin
						nec_ok = 1'b0;
					end
					nec_code = {nec_code[CODE_W-2:0], bit_val};
				end
				hash_step(last_mark, m);
				hash_step(last_space, s);
			end
			last_mark  = m;
			last_space = s;
			pair_count = pair_count + 1'b1;
		end
		if (last) begin
			n = pair_count;
			if (n >= 2) begin
				if (rpt_lead && n <= 4) begin
					expected_results.push_back({32'd0, KIND_REPEAT});
				end else if (nec_ok && n >= NEC_DATA_BITS + 1) begin
					expected_results.push_back({nec_code, KIND_NEC});
				end else if (n >= 6) begin
					expected_results.push_back({(timing_hash == 0) ? 32'd1 : timing_hash,
						KIND_HASH});
				end
			end
			clear_frame();
		end
	endtask

	initial begin
		fail_count = 0;
		pending    = 0;
		clear_frame();
	end

	always @(posedge clk) begin
		ir_result_t want;
		if (!arst_n) begin
			clear_frame();
		end else begin
			// The result side goes first: a result never stems from a pair taken
			// at the same edge.
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, code %h kind %0d, none expected",
						$time, res.code, res.kind);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (res.kind !== want.kind) begin
						$display("%0t: kind mismatch, expected %0d, got %0d",
							$time, want.kind, res.kind);
						fail_count++;
					end
					if (res.code !== want.code) begin
						$display("%0t: code mismatch, expected %h, got %h",
							$time, want.code, res.code);
						fail_count++;
					end
				end
			end
			if (sym.valid && sym.ready) begin
				decode_pair(sym.mark_ticks, sym.space_ticks, sym.frame_end);
			end
			pending = expected_results.size();
		end
	end
endmodule

>>> tb/sv/tb_top.sv
// Top of the infrared frame decoder bench. It builds frames of mark/space
// pairs, feeds them through the symbol channel with random gaps, drives the
// result channel's ready with random stalls, and gives the verdict from the
// failure and pending counts of the checker that sits beside the decoder.
module tb_top;
	import ifd_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int N_ITEMS = 750;
	// The last beats go out with neither side idling.
	localparam int TAIL_ITEMS = 100;
	// Long hold-off on the result side, so the decoder fills and stalls input.
	localparam int HOLD_CYCLES = 400;
	localparam int PRESSURE_AT = 300;
	// Cycles with no beat on either channel before the run is declared hung.
	// The worst legitimate stretch is the hold-off above.
	localparam int IDLE_LIMIT = 3000;
	// Long enough for a pair to pass through every state of the decoder.
	localparam int DRAIN_CYCLES = 40;
	localparam int TICK_MAX = (1 << TICK_W) - 1;

	typedef struct packed {
		logic [TICK_W-1:0] m;
		logic [TICK_W-1:0] s;
	} ir_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ifd_sym_if sym();
	ifd_res_if res();

	int       chk_fails;
	int       chk_pending;
	int       items_sent = 0;
	int       idle_cycles = 0;
	logic     quiet_tail = 1'b0;
	logic     hold_req = 1'b0;
	logic     hold_done = 1'b0;
	ir_pair_t frame_q[$];

	ir_frame_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym),
		.res    (res)
	);

	ifd_frame_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym        (sym),
		.res        (res),
		.fail_count (chk_fails),
		.pending    (chk_pending)
	);

	always #HALF_PERIOD clk = ~clk;

	// A duration inside the window around t, often right on one of its edges.
	function automatic int pick_near(input int t, input int w);
		case ($urandom_range(0, 5))
			0: return t - w;
			1: return t + w;
			default: return $urandom_range(t - w, t + w);
		endcase
	endfunction

	// A duration just outside the window around t, or far above it.
	function automatic int pick_off(input int t, input int w);
		case ($urandom_range(0, 2))
			0: return t - w - 1;
			1: return t + w + 1;
			default: return $urandom_range(t + w + 1, TICK_MAX);
		endcase
	endfunction

	// Durations for pairs that carry no NEC meaning: full scale, short, or
	// close to the bit timing so that the hash sees many similar neighbors.
	function automatic int pick_noise();
		case ($urandom_range(0, 2))
			0: return $urandom_range(0, TICK_MAX);
			1: return $urandom_range(0, 2000);
			default: return $urandom_range(400, 800);
		endcase
	endfunction

	task automatic add_pair(input int m, input int s);
		frame_q.push_back({TICK_W'(m), TICK_W'(s)});
	endtask

	// Queues an NEC-shaped frame of the given number of pairs: a data leader,
	// up to 32 bits of a random code, then noise. When broken is a pair index,
	// that pair is pushed out of its window.
	task automatic add_nec_frame(input int pairs, input int broken);
		logic [CODE_W-1:0] code;
		int                m;
		int                s;
		code = $urandom;
		for (int i = 0; i < pairs; i++) begin
			if (i == 0) begin
				m = pick_near(LEAD_MARK_T, LEAD_MARK_W);
				s = pick_near(DATA_SPACE_T, DATA_SPACE_W);
			end else if (i <= NEC_DATA_BITS) begin
				m = pick_near(BIT_T, BIT_W);
				s = code[NEC_DATA_BITS-i] ? pick_near(ONE_SPACE_T, ONE_SPACE_W) :
					pick_near(BIT_T, BIT_W);
			end else begin
				m = pick_noise();
				s = pick_noise();
			end
			if (i == broken) begin
				case ($urandom_range(0, 2))
					0: m = (i == 0) ? pick_off(LEAD_MARK_T, LEAD_MARK_W) :
						pick_off(BIT_T, BIT_W);
					// A space that falls between the two windows of its position.
					1: s = (i == 0) ?
						$urandom_range(RPT_SPACE_T + RPT_SPACE_W + 1,
							DATA_SPACE_T - DATA_SPACE_W - 1) :
						$urandom_range(BIT_T + BIT_W + 1, ONE_SPACE_T - ONE_SPACE_W - 1);
					default: s = (i == 0) ? pick_off(DATA_SPACE_T, DATA_SPACE_W) :
						pick_off(ONE_SPACE_T, ONE_SPACE_W);
				endcase
			end
			add_pair(m, s);
		end
	endtask

	// Offers one beat on the symbol channel, sometimes after an idle burst, and
	// holds it until the decoder takes it. Entered and left at a falling edge,
	// with valid left high so back-to-back beats need no extra assignment.
	task automatic send_pair(input logic [TICK_W-1:0] m, input logic [TICK_W-1:0] s,
		input logic last);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			sym.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		sym.valid       <= 1'b1;
		sym.mark_ticks  <= m;
		sym.space_ticks <= s;
		sym.frame_end   <= last;
		do @(posedge clk); while (!sym.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Sends the queued frame with frame_end on its last pair.
	task automatic send_frame();
		foreach (frame_q[i]) begin
			send_pair(frame_q[i].m, frame_q[i].s, i == frame_q.size() - 1);
		end
		frame_q.delete();
	endtask

	// Result side. Ready toggles in random bursts; once the sender asks for
	// pressure, it stays low for a long stretch counted here; in the tail it
	// stays high.
	initial begin
		res.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req && !hold_done) begin
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (quiet_tail) begin
				res.ready <= 1'b1;
				@(negedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end else begin
				res.ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
	end

	// Hang detection: any beat on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((sym.valid && sym.ready) || (res.valid && res.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int extras;
		sym.valid       = 1'b0;
		sym.mark_ticks  = '0;
		sym.space_ticks = '0;
		sym.frame_end   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames. A lone pair ends a frame too short for any result.
		add_pair(0, 0);
		send_frame();
		// The shortest repeat frame, its second pair at full-scale space.
		add_pair(LEAD_MARK_T, RPT_SPACE_T);
		add_pair(BIT_T, TICK_MAX);
		send_frame();
		// A repeat leader on the low edges of both windows, and four pairs, the
		// most a repeat frame may hold.
		add_pair(LEAD_MARK_T - LEAD_MARK_W, RPT_SPACE_T - RPT_SPACE_W);
		add_pair(TICK_MAX, TICK_MAX);
		add_pair(0, 0);
		add_pair(1, 16384);
		send_frame();
		// A repeat leader on the high edges, but five pairs: no longer a repeat,
		// and still too short for a hash, so nothing comes out.
		add_pair(LEAD_MARK_T + LEAD_MARK_W, RPT_SPACE_T + RPT_SPACE_W);
		add_pair(BIT_T, BIT_T);
		add_pair(BIT_T, ONE_SPACE_T);
		add_pair(BIT_T + BIT_W, ONE_SPACE_T + ONE_SPACE_W);
		add_pair(BIT_T - BIT_W, BIT_T - BIT_W);
		send_frame();
		// A leader mark one tick past its window and six pairs: a timing hash,
		// with longer, shorter and similar steps in it.
		add_pair(LEAD_MARK_T + LEAD_MARK_W + 1, DATA_SPACE_T);
		add_pair(TICK_MAX, 0);
		add_pair(0, TICK_MAX);
		add_pair(16384, 100);
		add_pair(100, 100);
		add_pair(120, 121);
		send_frame();
		// A data leader on the low edge of its space window, cut after one bit.
		add_pair(LEAD_MARK_T, DATA_SPACE_T - DATA_SPACE_W);
		add_pair(BIT_T, ONE_SPACE_T);
		send_frame();

		// A valid code followed by pairs past the frame limit, with frame_end on
		// a dropped pair.
		add_nec_frame($urandom_range(MAX_FRAME_SYMBOLS_DEF + 1, MAX_FRAME_SYMBOLS_DEF + 4), -1);
		send_frame();

		// Random frames, mostly well-formed with random content.
		while (items_sent < N_ITEMS) begin
			if (!hold_req && items_sent >= PRESSURE_AT) begin
				// Back-to-back repeat frames while the result side holds off, so a
				// result waits in the decoder and the next frame end stalls input.
				hold_req <= 1'b1;
				repeat (8) begin
					add_pair(LEAD_MARK_T, RPT_SPACE_T);
					add_pair(pick_noise(), pick_noise());
					send_frame();
				end
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: add_nec_frame($urandom_range(33, 36), -1);
					4, 5: add_nec_frame($urandom_range(33, 36), $urandom_range(0, 32));
					6, 7, 8, 9, 10: begin
						// One to three extra pairs keep a repeat; none gives nothing, and
						// more turn it into nothing or a hash.
						add_pair(pick_near(LEAD_MARK_T, LEAD_MARK_W),
							pick_near(RPT_SPACE_T, RPT_SPACE_W));
						extras = $urandom_range(0, 6);
						repeat (extras) add_pair(pick_noise(), pick_noise());
					end
					11, 12, 13, 14, 15: begin
						extras = $urandom_range(1, 12);
						repeat (extras) add_pair(pick_noise(), pick_noise());
					end
					16, 17, 18: add_nec_frame($urandom_range(2, 10), -1);
					default: add_nec_frame($urandom_range(93, 103),
						$urandom_range(0, 1) ? -1 : $urandom_range(0, 32));
				endcase
				send_frame();
			end
			if (items_sent >= N_ITEMS - TAIL_ITEMS) quiet_tail <= 1'b1;
		end
		sym.valid <= 1'b0;

		// Wait for every predicted result, then let the decoder settle so a
		// stray extra result would still be seen.
		while (chk_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (chk_fails == 0 && chk_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/ifd_pkg.sv
rtl/core/ifd_sym_if.sv
rtl/core/ifd_res_if.sv
rtl/core/ifd_hash_unit.sv
rtl/core/ir_frame_decoder.sv
tb/sv/ifd_frame_checker.sv
tb/sv/tb_top.sv
